@@ src/pwsc_pkg.sv @@
// Package: constants, codes and shared types of the pulse width switch classifier.
package pwsc_pkg;

	localparam int CHANNELS = 3;
	localparam int CFG_W    = 8;
	localparam int COUNT_W  = 8;
	localparam int CLASS_W  = 2;
	localparam int EVENT_W  = 2;
	localparam int IDX_W    = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LOW_THR  = 2'd1;
	localparam logic [IDX_W-1:0] REG_HIGH_THR = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0] WINDOW_RST   = 8'd250;
	localparam logic [CFG_W-1:0] LOW_THR_RST  = 8'd100;
	localparam logic [CFG_W-1:0] HIGH_THR_RST = 8'd200;

	// Class codes
	localparam logic [CLASS_W-1:0] CLASS_DOWN   = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_MIDDLE = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_UP     = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd3;

	// Event codes
	localparam logic [EVENT_W-1:0] EVENT_NONE = 2'd0;
	localparam logic [EVENT_W-1:0] EVENT_UP   = 2'd1;
	localparam logic [EVENT_W-1:0] EVENT_DOWN = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] window_ticks;
		logic [CFG_W-1:0] low_threshold;
		logic [CFG_W-1:0] high_threshold;
	} cfg_t;

	// Per-tick control from the sample stage to each channel
	typedef struct packed {
		logic advance;
		logic win_end;
	} chan_ctl_t;

endpackage

@@ src/pwsc_if.sv @@
// Interfaces: sample input channel and result output channel.
interface pwsc_in_if
	import pwsc_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [CHANNELS-1:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink (input valid, input pin_levels, output ready);
endinterface

interface pwsc_out_if
	import pwsc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] class_ch0;
	logic [CLASS_W-1:0] class_ch1;
	logic [CLASS_W-1:0] class_ch2;
	logic [EVENT_W-1:0] event_ch0;
	logic [EVENT_W-1:0] event_ch1;
	logic [EVENT_W-1:0] event_ch2;

	modport source (output valid, output class_ch0, output class_ch1, output class_ch2,
		output event_ch0, output event_ch1, output event_ch2, input ready);
	modport sink (input valid, input class_ch0, input class_ch1, input class_ch2,
		input event_ch0, input event_ch1, input event_ch2, output ready);
endinterface

@@ src/pwsc_cfg_regs.sv @@
// Configuration register file: window length and the two thresholds.
module pwsc_cfg_regs
	import pwsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// Register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ticks   <= WINDOW_RST;
			cfg_q.low_threshold  <= LOW_THR_RST;
			cfg_q.high_threshold <= HIGH_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW:   cfg_q.window_ticks   <= cfg_data;
				REG_LOW_THR:  cfg_q.low_threshold  <= cfg_data;
				REG_HIGH_THR: cfg_q.high_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/pwsc_chan.sv @@
// One channel: high-sample counter, window classification and change event.
module pwsc_chan
	import pwsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  chan_ctl_t          ctl,
	input  logic               pin,
	output logic [CLASS_W-1:0] cls,
	output logic [EVENT_W-1:0] evt
);

	logic [COUNT_W-1:0] count_q;
	logic [CLASS_W-1:0] prev_q;
	logic [COUNT_W-1:0] count_nxt;

	// Count this tick's sample, holding at full scale
	assign count_nxt = (pin && (count_q != {COUNT_W{1'b1}})) ? count_q + COUNT_W'(1) : count_q;

	// Classify the count including this tick
	always_comb begin
		if ((count_nxt >= cfg.low_threshold) && (count_nxt <= cfg.high_threshold))
			cls = CLASS_MIDDLE;
		else if (count_nxt < cfg.low_threshold)
			cls = CLASS_DOWN;
		else
			cls = CLASS_UP;
	end

	// Event on entering up or down
	always_comb begin
		if (cls == CLASS_UP && prev_q != CLASS_UP)
			evt = EVENT_UP;
		else if (cls == CLASS_DOWN && prev_q != CLASS_DOWN)
			evt = EVENT_DOWN;
		else
			evt = EVENT_NONE;
	end

	// Counter restarts and class is remembered at each window end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= CLASS_NONE;
		end else if (ctl.advance) begin
			if (ctl.win_end) begin
				count_q <= '0;
				prev_q  <= cls;
			end else begin
				count_q <= count_nxt;
			end
		end
	end

endmodule

@@ src/pulse_width_switch_classifier.sv @@
// Top level of the pulse width switch classifier.
//
// Usage: each item on in_ch carries one sampling tick, pin_levels bit i being
// the level of channel i. Per channel the block counts high samples over a
// window of window_ticks ticks (zero acts as one). On the tick that ends a
// window it emits one item on out_ch: the class of each channel (down,
// middle, up against low_threshold / high_threshold) and an event where a
// channel newly entered up or down. Other ticks produce no item.
// Configuration goes through cfg_we / cfg_index / cfg_data, written while idle.
// Order: a tick is taken into the sample register and counted into the
// channel counters as it leaves it; a window-end result is registered in the
// result register and presented on out_ch from there.
// Throughput: one tick per cycle, set by the single sample register and the
// result register behind it; a window-end tick waits while that one is full.
// Reset: counters and tick position clear, previous classes are "none",
// registers return to 250 / 100 / 200, all three channels come up empty.
// Stall: a full result register held by out_ch.ready low stops only a tick
// that ends a window; other ticks keep flowing, and in_ch.ready drops only
// once the sample register holds such a blocked tick.
module pulse_width_switch_classifier
	import pwsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	pwsc_in_if.sink          in_ch,
	pwsc_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t               cfg;
	chan_ctl_t          ctl;
	logic               s1_valid_s1;
	logic [CHANNELS-1:0] pins_s1;
	logic [CFG_W-1:0]   tick_q;
	logic [CFG_W-1:0]   window_eff;
	logic [CFG_W:0]     tick_next;
	logic               win_end;
	logic               advance;
	logic               out_valid_q;
	logic [CLASS_W-1:0] cls_c   [CHANNELS];
	logic [EVENT_W-1:0] evt_c   [CHANNELS];
	logic [CLASS_W-1:0] cls_q   [CHANNELS];
	logic [EVENT_W-1:0] evt_q   [CHANNELS];

	pwsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Window end detection
	assign window_eff = (cfg.window_ticks == '0) ? CFG_W'(1) : cfg.window_ticks;
	assign tick_next  = {1'b0, tick_q} + (CFG_W+1)'(1);
	assign win_end    = tick_next >= {1'b0, window_eff};

	// Sample stage moves unless its result finds the output register blocked
	assign advance     = s1_valid_s1 && (!win_end || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !s1_valid_s1 || advance;
	assign ctl.advance = advance;
	assign ctl.win_end = win_end;

	// Sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (in_ch.ready)
			s1_valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			pins_s1 <= in_ch.pin_levels;
	end

	// Tick position within the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tick_q <= '0;
		else if (advance)
			tick_q <= win_end ? '0 : tick_next[CFG_W-1:0];
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		pwsc_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg),
			.ctl    (ctl),
			.pin    (pins_s1[g]),
			.cls    (cls_c[g]),
			.evt    (evt_c[g])
		);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && win_end)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && win_end) begin
			cls_q <= cls_c;
			evt_q <= evt_c;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.class_ch0 = cls_q[0];
	assign out_ch.class_ch1 = cls_q[1];
	assign out_ch.class_ch2 = cls_q[2];
	assign out_ch.event_ch0 = evt_q[0];
	assign out_ch.event_ch1 = evt_q[1];
	assign out_ch.event_ch2 = evt_q[2];

	// A reported class is always a real class
	a_class_real: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cls_q[0] != CLASS_NONE && cls_q[1] != CLASS_NONE &&
			cls_q[2] != CLASS_NONE))
		else $error("result carries no-class code");

	// On channel 0, an up event comes only with an up class
	a_event_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evt_q[0] == EVENT_UP |-> cls_q[0] == CLASS_UP)
		else $error("up event without up class");

	// On channel 1, a down event comes only with a down class
	a_event_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evt_q[1] == EVENT_DOWN |-> cls_q[1] == CLASS_DOWN)
		else $error("down event without down class");

	// A window end restarts the tick position and presents a result
	a_window_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && win_end |=> tick_q == '0 && out_valid_q)
		else $error("window end did not restart window");

endmodule

@@ bench/pwsc_report_monitor.sv @@
`timescale 1ns / 1ps
// Window report monitor: predicts every window-end report from the accepted ticks and checks it.
module pwsc_report_monitor
	import pwsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	pwsc_in_if               in_mon,
	pwsc_out_if              out_mon,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               reports_due
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [CHANNELS-1:0][CLASS_W-1:0] cls;
		logic [CHANNELS-1:0][EVENT_W-1:0] evt;
	} switch_report_t;

	// Shadow registers and window state
	logic [CFG_W-1:0]   window_len;
	logic [CFG_W-1:0]   low_thr;
	logic [CFG_W-1:0]   high_thr;
	logic [COUNT_W-1:0] tick_pos;
	logic [COUNT_W-1:0] high_count [CHANNELS];
	logic [CLASS_W-1:0] last_class [CHANNELS];
	switch_report_t     report_queue [$];
	int                 errors;

	// Down below low_thr, middle inside the band, up otherwise (low above high: no middle)
	function automatic logic [CLASS_W-1:0] grade_count(input logic [COUNT_W-1:0] cnt);
		if (cnt >= low_thr && cnt <= high_thr)
			return CLASS_MIDDLE;
		if (cnt < low_thr)
			return CLASS_DOWN;
		return CLASS_UP;
	endfunction

	// One tick: count high pins, and on the window's last tick queue the report
	function automatic void take_sample(input logic [CHANNELS-1:0] pins);
		int             span;
		int             next_pos;
		switch_report_t rpt;
		span = (window_len == '0) ? 1 : int'(window_len);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (pins[ch] && high_count[ch] != '1)
				high_count[ch] = high_count[ch] + 1'b1;
		end
		next_pos = int'(tick_pos) + 1;
		if (next_pos < span) begin
			tick_pos = COUNT_W'(next_pos);
			return;
		end
		tick_pos = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			rpt.cls[ch] = grade_count(high_count[ch]);
			rpt.evt[ch] = EVENT_NONE;
			if (rpt.cls[ch] == CLASS_UP && last_class[ch] != CLASS_UP)
				rpt.evt[ch] = EVENT_UP;
			else if (rpt.cls[ch] == CLASS_DOWN && last_class[ch] != CLASS_DOWN)
				rpt.evt[ch] = EVENT_DOWN;
			last_class[ch] = rpt.cls[ch];
			high_count[ch] = '0;
		end
		report_queue.push_back(rpt);
	endfunction

	function automatic void note_mismatch(input string field, input int ch,
			input logic [1:0] want, input logic [1:0] got);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t: %s%0d mismatch: expected %0d, got %0d", $realtime, field, ch, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		switch_report_t got;
		switch_report_t want;
		if (!arst_n) begin
			window_len = WINDOW_RST;
			low_thr    = LOW_THR_RST;
			high_thr   = HIGH_THR_RST;
			tick_pos   = '0;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				high_count[ch] = '0;
				last_class[ch] = CLASS_NONE;
			end
			report_queue.delete();
			errors = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW:   window_len = cfg_data;
					REG_LOW_THR:  low_thr    = cfg_data;
					REG_HIGH_THR: high_thr   = cfg_data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				take_sample(in_mon.pin_levels);
			// compare a delivered report with the oldest prediction
			if (out_mon.valid && out_mon.ready) begin
				got.cls[0] = out_mon.class_ch0;
				got.cls[1] = out_mon.class_ch1;
				got.cls[2] = out_mon.class_ch2;
				got.evt[0] = out_mon.event_ch0;
				got.evt[1] = out_mon.event_ch1;
				got.evt[2] = out_mon.event_ch2;
				if (report_queue.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: report with none expected: %h", $realtime, got);
				end else begin
					want = report_queue.pop_front();
					for (int ch = 0; ch < CHANNELS; ch++) begin
						if (got.cls[ch] !== want.cls[ch])
							note_mismatch("class_ch", ch, want.cls[ch], got.cls[ch]);
						if (got.evt[ch] !== want.evt[ch])
							note_mismatch("event_ch", ch, want.evt[ch], got.evt[ch]);
					end
				end
			end
		end
		fail_count  <= errors;
		reports_due <= report_queue.size();
	end

endmodule

@@ bench/pulse_width_switch_classifier_tb.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, tick stimulus, result backpressure, watchdog and verdict.
module pulse_width_switch_classifier_tb;
	import pwsc_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_TICKS   = 90;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               sender_idle_pct;
	int               receiver_idle_pct;
	int               fail_count;
	int               reports_due;
	int               quiet_cycles;

	pwsc_in_if  in_ch ();
	pwsc_out_if out_ch ();

	pulse_width_switch_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pwsc_report_monitor report_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.reports_due (reports_due)
	);

	always #5 clk = ~clk;

	// result side stalls
	initial out_ch.ready = 1'b0;
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// watchdog: too long without any item or write moving
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_tick(input logic [CHANNELS-1:0] pins);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.pin_levels <= pins;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// hold ticks back until every predicted report has been delivered
	task automatic drain_reports();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] hi);
		drain_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WINDOW;
		cfg_data  <= win;
		@(posedge clk);
		cfg_index <= REG_LOW_THR;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_HIGH_THR;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random pins with a per-channel duty that changes about once per window
	task automatic run_ticks(input int n_items, input logic [CFG_W-1:0] win);
		int                  duty [CHANNELS];
		int                  span;
		int                  left;
		logic [CHANNELS-1:0] pins;
		span = (win == '0) ? 1 : int'(win);
		left = 0;
		for (int i = 0; i < n_items; i++) begin
			if (left == 0) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					case ($urandom_range(5))
						0:       duty[ch] = 0;
						1:       duty[ch] = 100;
						default: duty[ch] = $urandom_range(100);
					endcase
				end
				left = span;
			end
			left--;
			for (int ch = 0; ch < CHANNELS; ch++)
				pins[ch] = ($urandom_range(99) < duty[ch]);
			send_tick(pins);
			if (i == n_items / 2)
				drain_reports();
		end
	endtask

	// mostly short windows so reports come often; thresholds around the window length
	task automatic random_phase(input int n_items);
		logic [CFG_W-1:0] win;
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		int               span;
		case ($urandom_range(9))
			0:       win = '0;
			9:       win = CFG_W'($urandom_range(60, 17));
			default: win = CFG_W'($urandom_range(16, 1));
		endcase
		span = (win == '0) ? 1 : int'(win);
		lo = CFG_W'($urandom_range(span + 1, 0));
		hi = CFG_W'($urandom_range(span + 1, 0));
		if ($urandom_range(7) == 0)
			hi = '1;
		if ($urandom_range(7) == 0)
			lo = '0;
		apply_settings(win, lo, hi);
		run_ticks(n_items, win);
	endtask

	initial begin
		arst_n            = 1'b0;
		sender_idle_pct   = 30;
		receiver_idle_pct = 71;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_WINDOW;
		cfg_data         <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.pin_levels <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// first window from no class: ch0 up, ch1 down, ch2 middle
		apply_settings(8'd4, 8'd1, 8'd2);
		send_tick(3'b101);
		send_tick(3'b101);
		send_tick(3'b001);
		send_tick(3'b001);

		// zero-length window acts as one tick; low above high leaves no middle
		apply_settings(8'd0, 8'd1, 8'd0);
		send_tick(3'b111);
		send_tick(3'b111);
		send_tick(3'b000);
		send_tick(3'b101);
		send_tick(3'b010);
		send_tick(3'b000);

		// window shortened below the current position ends it on the next tick
		apply_settings(8'd8, 8'd2, 8'd3);
		send_tick(3'b111);
		send_tick(3'b011);
		send_tick(3'b001);
		send_tick(3'b110);
		send_tick(3'b000);
		apply_settings(8'd3, 8'd2, 8'd3);
		send_tick(3'b101);

		// widest band: every count is middle
		apply_settings(8'd2, 8'd0, 8'd255);
		send_tick(3'b010);
		send_tick(3'b111);

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					sender_idle_pct   = 30;
					receiver_idle_pct = 71;
				end
				1: begin
					sender_idle_pct   = 71;
					receiver_idle_pct = 30;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (int p = 0; p < 5; p++)
				random_phase(PHASE_TICKS);
		end

		// longest window, all pins high: counts reach the top of their range
		apply_settings(8'd255, 8'd255, 8'd254);
		for (int i = 0; i < 255; i++)
			send_tick('1);
		run_ticks(255, 8'd255);

		drain_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && reports_due == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
